[design/ibnd_pkg.sv]
// Shared types and constants of the RGBA image downscaler.
// No dependencies; every other design file but ibnd_ram refers to it by scoped names.
`default_nettype none
package ibnd_pkg;

  localparam int MAX_SOURCE_SIDE = 4096;
  localparam int MAX_OUT_SIDE    = 1024;

  localparam int SIDE_W  = $clog2(MAX_SOURCE_SIDE) + 1;  // holds a side length
  localparam int POS_W   = $clog2(MAX_SOURCE_SIDE);      // holds a source position
  localparam int OSIDE_W = $clog2(MAX_OUT_SIDE) + 1;     // holds the output side
  localparam int COL_W   = $clog2(MAX_OUT_SIDE);         // output column / row
  localparam int SUM_W   = 32;
  localparam int AREA_W  = 2 * POS_W + 1;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = SIDE_W;
  localparam int CH_N    = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_SIZE      = 2'd2;

  localparam logic [SIDE_W-1:0]  RESET_SOURCE_WIDTH  = SIDE_W'(256);
  localparam logic [SIDE_W-1:0]  RESET_SOURCE_HEIGHT = SIDE_W'(256);
  localparam logic [OSIDE_W-1:0] RESET_OUT_SIZE      = OSIDE_W'(32);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_t;

  typedef enum logic {
    OP_NEAR,
    OP_BOX
  } op_t;

  // one unit of work handed from front to back
  typedef struct packed {
    op_t              op;
    logic             first;
    logic             emit;
    logic             frame_end;
    logic [COL_W-1:0] col;
    pixel_t           pix;
  } cmd_t;

endpackage
`default_nettype wire

[design/ibnd_if.sv]
// Channel interfaces of the downscaler: source pixels, output pixels, config writes.
// Depends on ibnd_pkg for widths.
`default_nettype none
interface ibnd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  logic [7:0] in_alpha;
  logic       frame_start;
  modport source(output valid, in_red, in_green, in_blue, in_alpha, frame_start,
                 input ready);
  modport sink(input valid, in_red, in_green, in_blue, in_alpha, frame_start,
               output ready);
endinterface

interface ibnd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;
  logic       frame_end;
  modport source(output valid, out_red, out_green, out_blue, out_alpha, frame_end,
                 input ready);
  modport sink(input valid, out_red, out_green, out_blue, out_alpha, frame_end,
               output ready);
endinterface

interface ibnd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ibnd_pkg::CFG_IDX_W-1:0]  index;
  logic [ibnd_pkg::CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

[design/ibnd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ibnd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

[design/ibnd_queue.sv]
// Two-entry command queue between front and back.
// Depends on ibnd_pkg for cmd_t.
`default_nettype none
module ibnd_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire ibnd_pkg::cmd_t din,
  output logic                full,
  input  wire logic           pop,
  output ibnd_pkg::cmd_t      dout,
  output logic                empty
);

  ibnd_pkg::cmd_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign dout  = mem_r[rp_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

[design/ibnd_front.sv]
// Front part: config registers, size setup divider, raster position tracking
// and classification of each source word into a back-end command.
// Depends on ibnd_pkg and the channel interfaces.
`default_nettype none
module ibnd_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  ibnd_in_if.sink                            in_ch,
  ibnd_cfg_if.sink                           cfg_ch,
  output logic                               push,
  output ibnd_pkg::cmd_t                     cmd,
  input  wire logic                          full,
  output logic [ibnd_pkg::AREA_W-1:0]        area
);

  localparam int SW = ibnd_pkg::SIDE_W;
  localparam int PW = ibnd_pkg::POS_W;
  localparam int OW = ibnd_pkg::OSIDE_W;
  localparam int CW = ibnd_pkg::COL_W;

  typedef enum logic [1:0] {ST_LOAD, ST_DIV, ST_AREA, ST_RUN} state_t;

  state_t        state_r;
  logic [SW-1:0] w_r, h_r;
  logic [OW-1:0] s_r;
  logic [SW-1:0] wq_r, hq_r;   // dividend shifts out, quotient shifts in
  logic [OW-1:0] wr_r, hr_r;
  logic [3:0]    cnt_r;
  logic [ibnd_pkg::AREA_W-1:0] area_r;
  logic          box_r;

  logic [SW-1:0] weff, heff;
  logic [OW-1:0] seff, s_m1;
  logic          cfg_hit;

  // clamp sizes; output side never exceeds either source side
  always_comb begin
    logic [SW-1:0] s1;
    weff = (w_r == '0) ? SW'(1) :
           (w_r > SW'(ibnd_pkg::MAX_SOURCE_SIDE)) ? SW'(ibnd_pkg::MAX_SOURCE_SIDE) : w_r;
    heff = (h_r == '0) ? SW'(1) :
           (h_r > SW'(ibnd_pkg::MAX_SOURCE_SIDE)) ? SW'(ibnd_pkg::MAX_SOURCE_SIDE) : h_r;
    s1   = (s_r == '0) ? SW'(1) :
           (s_r > OW'(ibnd_pkg::MAX_OUT_SIDE)) ? SW'(ibnd_pkg::MAX_OUT_SIDE) : SW'(s_r);
    if (s1 > weff) s1 = weff;
    if (s1 > heff) s1 = heff;
    seff   = s1[OW-1:0];
    s_m1   = seff - OW'(1);
  end

  // one restoring division step: {quotient/dividend, remainder}
  function automatic logic [SW+OW-1:0] div_step(logic [SW-1:0] q, logic [OW-1:0] r,
                                                logic [OW-1:0] d);
    logic [OW:0] sh;
    logic [OW:0] df;
    sh = {r, q[SW-1]};
    df = sh - {1'b0, d};
    if (sh >= {1'b0, d}) begin
      return {q[SW-2:0], 1'b1, df[OW-1:0]};
    end
    return {q[SW-2:0], 1'b0, sh[OW-1:0]};
  endfunction

  assign cfg_ch.ready = 1'b1;
  assign cfg_hit = cfg_ch.valid && (cfg_ch.index == ibnd_pkg::REG_SOURCE_WIDTH ||
                   cfg_ch.index == ibnd_pkg::REG_SOURCE_HEIGHT ||
                   cfg_ch.index == ibnd_pkg::REG_OUT_SIZE);

  // setup sequencer: W/S and H/S by 13-step division, then block area
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      w_r     <= ibnd_pkg::RESET_SOURCE_WIDTH;
      h_r     <= ibnd_pkg::RESET_SOURCE_HEIGHT;
      s_r     <= ibnd_pkg::RESET_OUT_SIZE;
      cnt_r   <= '0;
    end else if (cfg_hit) begin
      unique case (cfg_ch.index)
        ibnd_pkg::REG_SOURCE_WIDTH:  w_r <= cfg_ch.data;
        ibnd_pkg::REG_SOURCE_HEIGHT: h_r <= cfg_ch.data;
        default:                     s_r <= cfg_ch.data[OW-1:0];
      endcase
      state_r <= ST_LOAD;
    end else begin
      unique case (state_r)
        ST_LOAD: begin
          wq_r    <= weff;
          hq_r    <= heff;
          wr_r    <= '0;
          hr_r    <= '0;
          cnt_r   <= 4'(SW - 1);
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          {wq_r, wr_r} <= div_step(wq_r, wr_r, seff);
          {hq_r, hr_r} <= div_step(hq_r, hr_r, seff);
          cnt_r        <= cnt_r - 4'd1;
          if (cnt_r == '0) state_r <= ST_AREA;
        end
        ST_AREA: begin
          area_r  <= ibnd_pkg::AREA_W'(wq_r * wq_r);
          box_r   <= (weff == heff) && (wr_r == '0);
          state_r <= ST_RUN;
        end
        default: state_r <= ST_RUN;
      endcase
    end
  end

  assign area = area_r;
  assign in_ch.ready = (state_r == ST_RUN) && !full;

  // raster position and pick counters
  logic [PW-1:0] sc_r, sr_r, cx_r, cy_r, npc_r;
  logic [CW-1:0] col_r, row_r;
  logic [OW-1:0] oc_r, or_r, crem_r, rrem_r;
  logic [SW-1:0] npr_r;

  logic [PW-1:0] sc_e, sr_e, cx_e, cy_e, npc_e, f_m1;
  logic [CW-1:0] col_e, row_e;
  logic [OW-1:0] oc_e, or_e, crem_e, rrem_e;
  logic [SW-1:0] npr_e;
  logic          acc, hit, col_last, row_last;

  always_comb begin
    if (in_ch.frame_start) begin
      sc_e = '0; sr_e = '0; cx_e = '0; cy_e = '0; npc_e = '0;
      col_e = '0; row_e = '0; oc_e = '0; or_e = '0; crem_e = '0; rrem_e = '0;
      npr_e = '0;
    end else begin
      sc_e = sc_r; sr_e = sr_r; cx_e = cx_r; cy_e = cy_r; npc_e = npc_r;
      col_e = col_r; row_e = row_r; oc_e = oc_r; or_e = or_r; crem_e = crem_r;
      rrem_e = rrem_r; npr_e = npr_r;
    end
  end

  assign acc      = in_ch.valid && in_ch.ready;
  assign f_m1     = PW'(wq_r - SW'(1));
  assign hit      = (or_e < seff) && (SW'(sr_e) == npr_e) && (sc_e == npc_e);
  assign col_last = (SW'(sc_e) + SW'(1)) == weff;
  assign row_last = (SW'(sr_e) + SW'(1)) == heff;
  assign push     = acc && (box_r || hit);

  // command build
  always_comb begin
    cmd.pix = '{red: in_ch.in_red, green: in_ch.in_green, blue: in_ch.in_blue,
                alpha: in_ch.in_alpha};
    cmd.col = col_e;
    if (box_r) begin
      cmd.op        = ibnd_pkg::OP_BOX;
      cmd.first     = (cx_e == '0) && (cy_e == '0);
      cmd.emit      = (cx_e == f_m1) && (cy_e == f_m1);
      cmd.frame_end = ({1'b0, col_e} == s_m1) && ({1'b0, row_e} == s_m1);
    end else begin
      cmd.op        = ibnd_pkg::OP_NEAR;
      cmd.first     = 1'b0;
      cmd.emit      = 1'b1;
      cmd.frame_end = (or_e == s_m1) && (oc_e == s_m1);
    end
  end

  always_ff @(posedge clk) begin
    logic [OW:0]   csum, rsum;
    logic          cge, rge;
    logic [OW-1:0] oc_n;
    csum = {1'b0, crem_e} + {1'b0, wr_r};
    rsum = {1'b0, rrem_e} + {1'b0, hr_r};
    cge  = csum >= {1'b0, seff};
    rge  = rsum >= {1'b0, seff};
    oc_n = oc_e + OW'(1);
    if (!rst_n || cfg_hit || (acc && col_last && row_last)) begin
      sc_r <= '0; sr_r <= '0; cx_r <= '0; cy_r <= '0; npc_r <= '0;
      col_r <= '0; row_r <= '0; oc_r <= '0; or_r <= '0; crem_r <= '0; rrem_r <= '0;
      npr_r <= '0;
    end else if (acc) begin
      // source position and box block counters
      if (col_last) begin
        sc_r  <= '0;
        sr_r  <= sr_e + PW'(1);
        cx_r  <= '0;
        col_r <= '0;
        if (cy_e == f_m1) begin
          cy_r  <= '0;
          row_r <= row_e + CW'(1);
        end else begin
          cy_r  <= cy_e + PW'(1);
          row_r <= row_e;
        end
      end else begin
        sc_r <= sc_e + PW'(1);
        sr_r <= sr_e;
        cy_r <= cy_e;
        row_r <= row_e;
        if (cx_e == f_m1) begin
          cx_r  <= '0;
          col_r <= col_e + CW'(1);
        end else begin
          cx_r  <= cx_e + PW'(1);
          col_r <= col_e;
        end
      end
      // nearest pick: advance next source position incrementally
      oc_r <= oc_e; or_r <= or_e; npc_r <= npc_e; npr_r <= npr_e;
      crem_r <= crem_e; rrem_r <= rrem_e;
      if (!box_r && hit) begin
        if (oc_n == seff) begin
          oc_r   <= '0;
          or_r   <= or_e + OW'(1);
          npc_r  <= '0;
          crem_r <= '0;
          npr_r  <= SW'(npr_e + hq_r + SW'(rge));
          rrem_r <= rge ? OW'(rsum - {1'b0, seff}) : rsum[OW-1:0];
        end else begin
          oc_r   <= oc_n;
          npc_r  <= PW'(SW'(npc_e) + wq_r + SW'(cge));
          crem_r <= cge ? OW'(csum - {1'b0, seff}) : csum[OW-1:0];
        end
      end
    end
  end

endmodule
`default_nettype wire

[design/ibnd_back.sv]
// Back part: per-column block sums in RAM, 8-step mean divider, output register.
// Depends on ibnd_pkg, ibnd_ram and the output interface.
`default_nettype none
module ibnd_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       empty,
  output logic                            pop,
  input  wire ibnd_pkg::cmd_t             cmd,
  input  wire logic [ibnd_pkg::AREA_W-1:0] area,
  ibnd_out_if.source                      out_ch
);

  localparam int NC = ibnd_pkg::CH_N;
  localparam int SW = ibnd_pkg::SUM_W;

  typedef enum logic [1:0] {B_IDLE, B_RMW, B_DIV, B_OUT} state_t;

  state_t               state_r;
  ibnd_pkg::cmd_t       cmd_r;
  logic [NC-1:0][SW-1:0] rem_r;
  logic [NC-1:0][7:0]   q_r;
  logic [SW-1:0]        dvs_r;
  logic [2:0]           step_r;
  logic                 out_valid_r;
  logic [NC-1:0][7:0]   out_pix_r;
  logic                 out_fe_r;

  logic [NC-1:0][SW-1:0] rd, sum_new;
  logic [NC-1:0][7:0]   px;
  logic                 we, load_out;

  assign pop = (state_r == B_IDLE) && !empty;
  assign px  = cmd_r.pix;
  assign we  = (state_r == B_RMW);

  // block sum: restart on the first word of a block, else accumulate
  always_comb begin
    for (int i = 0; i < NC; i++) begin
      sum_new[i] = cmd_r.first ? SW'(px[i]) : rd[i] + SW'(px[i]);
    end
  end

  ibnd_ram #(.WIDTH(NC * SW), .DEPTH(ibnd_pkg::MAX_OUT_SIDE)) u_sum_ram (
    .clk   (clk),
    .we    (we),
    .waddr (cmd_r.col),
    .wdata (sum_new),
    .raddr (cmd.col),
    .rdata (rd)
  );

  assign load_out = (state_r == B_OUT) && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // output word stays until taken, reloaded in the same cycle if possible
      out_valid_r <= load_out || (out_valid_r && !out_ch.ready);
      unique case (state_r)
        B_IDLE: begin
          if (!empty) begin
            cmd_r <= cmd;
            q_r   <= cmd.pix;
            state_r <= (cmd.op == ibnd_pkg::OP_BOX) ? B_RMW : B_OUT;
          end
        end
        B_RMW: begin
          rem_r   <= sum_new;
          dvs_r   <= {area, 7'd0};
          step_r  <= 3'd7;
          state_r <= cmd_r.emit ? B_DIV : B_IDLE;
        end
        B_DIV: begin
          // one quotient bit per channel per cycle
          for (int i = 0; i < NC; i++) begin
            if (rem_r[i] >= dvs_r) begin
              rem_r[i] <= rem_r[i] - dvs_r;
              q_r[i]   <= {q_r[i][6:0], 1'b1};
            end else begin
              q_r[i]   <= {q_r[i][6:0], 1'b0};
            end
          end
          dvs_r  <= dvs_r >> 1;
          step_r <= step_r - 3'd1;
          if (step_r == 3'd0) state_r <= B_OUT;
        end
        default: begin
          if (load_out) begin
            out_pix_r   <= q_r;
            out_fe_r    <= cmd_r.frame_end;
            state_r     <= B_IDLE;
          end
        end
      endcase
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_red   = out_pix_r[3];
  assign out_ch.out_green = out_pix_r[2];
  assign out_ch.out_blue  = out_pix_r[1];
  assign out_ch.out_alpha = out_pix_r[0];
  assign out_ch.frame_end = out_fe_r;

endmodule
`default_nettype wire

[design/image_box_or_nearest_downscaler.sv]
// Top level of the RGBA image downscaler: front, command queue and back.
// Depends on ibnd_pkg, the channel interfaces, ibnd_front, ibnd_queue, ibnd_back.
//
// Source words arrive in raster order and an out_size x out_size image leaves
// in raster order. A square source whose width is a multiple of out_size is
// box-averaged (floor of the block mean per channel); any other shape is
// decimated by nearest pick. The front takes source words only while the
// two-entry queue has room. The back reads, then writes the sum RAM for each
// queued box word, and a finished box block then runs the 8-step mean divider
// and the output load; nearest mode queues only picked words, which go
// straight to the output load. The back takes no new queued word until it is
// through with the last. After reset and after every write to a configuration
// register the input is held off while the front divides the sides by
// out_size and forms the block area. Configuration writes are always taken.
`default_nettype none
module image_box_or_nearest_downscaler (
  input  wire logic   clk,
  input  wire logic   rst_n,
  ibnd_in_if.sink     in_ch,
  ibnd_out_if.source  out_ch,
  ibnd_cfg_if.sink    cfg_ch
);

  logic                         push, full, pop, empty;
  ibnd_pkg::cmd_t               cmd_in, cmd_out;
  logic [ibnd_pkg::AREA_W-1:0]  area;

  ibnd_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .push   (push),
    .cmd    (cmd_in),
    .full   (full),
    .area   (area)
  );

  ibnd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (cmd_in),
    .full  (full),
    .pop   (pop),
    .dout  (cmd_out),
    .empty (empty)
  );

  ibnd_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .cmd    (cmd_out),
    .area   (area),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

[design/ibnd_checker.sv]
// Port-level checks of the downscaler, bound to the top level.
// Depends on ibnd_pkg for register indexes.
`default_nettype none
module ibnd_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_ready,
  input wire logic                           cfg_valid,
  input wire logic                           cfg_ready,
  input wire logic [ibnd_pkg::CFG_IDX_W-1:0] cfg_index,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [32:0]                    out_word
);

  // a register write reruns setup, so input is held off next cycle
  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready && (cfg_index == ibnd_pkg::REG_SOURCE_WIDTH ||
    cfg_index == ibnd_pkg::REG_SOURCE_HEIGHT || cfg_index == ibnd_pkg::REG_OUT_SIZE)
    |=> !in_ready)
    else $error("input ready right after config write");

  // setup runs after reset
  a_reset_blocks_input: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input ready right after reset");

  a_reset_no_output: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("output word dropped or changed while stalled");

endmodule

bind image_box_or_nearest_downscaler ibnd_checker u_ibnd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .cfg_valid (cfg_ch.valid),
  .cfg_ready (cfg_ch.ready),
  .cfg_index (cfg_ch.index),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_word  ({out_ch.frame_end, out_ch.out_red, out_ch.out_green, out_ch.out_blue,
               out_ch.out_alpha})
);
`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the RGBA box / nearest image downscaler.
// Depends on ibnd_pkg, the ibnd channel interfaces and image_box_or_nearest_downscaler.
`timescale 1ns / 1ps
module tb;

  localparam int TIMEOUT_CYCLES = 2_000_000;
  localparam int DRAIN_CYCLES   = 40;

  typedef struct {
    ibnd_pkg::pixel_t pix;
    bit               fe;
  } out_word_t;

  typedef struct {
    bit                              is_cfg;
    logic [ibnd_pkg::CFG_IDX_W-1:0]  idx;
    logic [ibnd_pkg::CFG_DATA_W-1:0] val;
    ibnd_pkg::pixel_t                pix;
    bit                              fs;
    bit                              typed;
    out_word_t                       ew;
  } stim_row_t;

  logic clk;
  logic rst_n;
  ibnd_in_if  in_ch();
  ibnd_out_if out_ch();
  ibnd_cfg_if cfg_ch();

  image_box_or_nearest_downscaler u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // 4 ns clock
  always begin
    clk = 1'b0; #2;
    clk = 1'b1; #2;
  end

  // predictor state
  int unsigned src_w, src_h, out_sz;
  int unsigned pos_col, pos_row, pick_ocol, pick_orow, pick_scol, pick_srow;
  bit [31:0]   blk_sum[4][ibnd_pkg::MAX_OUT_SIDE];
  out_word_t   exp_words[$];

  int          err_cnt;
  int          idle_mode;  // 0 none, 1 sender gaps, 2 receiver stalls, 3 both
  bit          hold_req;
  int          hold_left;
  longint      cycle_cnt;

  function automatic int unsigned clamp_side(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void restart_pos();
    pos_col = 0; pos_row = 0;
    pick_ocol = 0; pick_orow = 0;
    pick_scol = 0; pick_srow = 0;
  endfunction

  function automatic void cfg_predict(logic [ibnd_pkg::CFG_IDX_W-1:0] idx,
                                      logic [ibnd_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      ibnd_pkg::REG_SOURCE_WIDTH:  src_w = val & 13'h1FFF;
      ibnd_pkg::REG_SOURCE_HEIGHT: src_h = val & 13'h1FFF;
      ibnd_pkg::REG_OUT_SIZE:      out_sz = val & 13'h07FF;
      default: return;
    endcase
    restart_pos();
  endfunction

  // expected result of one accepted source word; returns 1 if one comes out
  function automatic bit downscale_word(ibnd_pkg::pixel_t p, bit fs, output out_word_t ow);
    int unsigned w, h, s, f, col, row, cx, cy;
    bit [7:0]    ch[4];
    longint unsigned area;
    bit          hit;
    hit = 0;
    ow = '{pix: '0, fe: 0};
    w = clamp_side(src_w, ibnd_pkg::MAX_SOURCE_SIDE);
    h = clamp_side(src_h, ibnd_pkg::MAX_SOURCE_SIDE);
    s = clamp_side(out_sz, ibnd_pkg::MAX_OUT_SIDE);
    if (s > w) s = w;
    if (s > h) s = h;
    ch[0] = p.red; ch[1] = p.green; ch[2] = p.blue; ch[3] = p.alpha;
    if (fs) restart_pos();
    if (pos_col >= w || pos_row >= h) restart_pos();

    if (w == h && (w % s) == 0) begin
      // box mean over f x f blocks
      f = w / s;
      col = pos_col / f; row = pos_row / f;
      cx = pos_col % f;  cy = pos_row % f;
      for (int k = 0; k < 4; k++) begin
        if (cx == 0 && cy == 0) blk_sum[k][col] = ch[k];
        else blk_sum[k][col] += ch[k];
      end
      if (cx == f - 1 && cy == f - 1) begin
        area = longint'(f) * f;
        ow.pix.red   = 8'(longint'(blk_sum[0][col]) / area);
        ow.pix.green = 8'(longint'(blk_sum[1][col]) / area);
        ow.pix.blue  = 8'(longint'(blk_sum[2][col]) / area);
        ow.pix.alpha = 8'(longint'(blk_sum[3][col]) / area);
        ow.fe = (col == s - 1 && row == s - 1);
        hit = 1;
      end
    end else if (pick_orow < s && pos_row == pick_srow && pos_col == pick_scol) begin
      // nearest pick
      ow.pix = p;
      ow.fe = (pick_orow == s - 1 && pick_ocol == s - 1);
      hit = 1;
      pick_ocol++;
      if (pick_ocol >= s) begin
        pick_ocol = 0;
        pick_orow++;
        pick_srow = int'((longint'(pick_orow) * h) / s);
      end
      pick_scol = int'((longint'(pick_ocol) * w) / s);
    end

    pos_col++;
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row++;
      if (pos_row >= h) restart_pos();
    end
    return hit;
  endfunction

  function automatic bit sender_gap();
    if (idle_mode == 1) return $urandom_range(99) < 77;
    if (idle_mode == 3) return $urandom_range(99) < 20;
    return 0;
  endfunction

  // drive one source word; call and return at a falling edge
  task automatic send_pixel(ibnd_pkg::pixel_t p, bit fs, bit typed, out_word_t ew);
    out_word_t pw;
    while (sender_gap()) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid       = 1'b1;
    in_ch.in_red      = p.red;
    in_ch.in_green    = p.green;
    in_ch.in_blue     = p.blue;
    in_ch.in_alpha    = p.alpha;
    in_ch.frame_start = fs;
    do @(posedge clk); while (!in_ch.ready);
    if (downscale_word(p, fs, pw) && !typed) exp_words.insert(exp_words.size(), pw);
    if (typed) exp_words.insert(exp_words.size(), ew);
    @(negedge clk);
  endtask

  // register write once all results are out and the back end has settled
  task automatic cfg_write(logic [ibnd_pkg::CFG_IDX_W-1:0] idx,
                           logic [ibnd_pkg::CFG_DATA_W-1:0] val);
    in_ch.valid = 1'b0;
    while (exp_words.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_predict(idx, val);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  function automatic stim_row_t cfg_row(logic [ibnd_pkg::CFG_IDX_W-1:0] idx, int val);
    stim_row_t r;
    r = '{default: '0};
    r.is_cfg = 1; r.idx = idx; r.val = ibnd_pkg::CFG_DATA_W'(val);
    return r;
  endfunction

  function automatic stim_row_t pix_row(logic [31:0] p, bit fs, bit typed = 0,
                                        logic [31:0] ep = '0, bit efe = 0);
    stim_row_t r;
    r = '{default: '0};
    r.pix = p; r.fs = fs; r.typed = typed;
    r.ew = '{pix: ep, fe: efe};
    return r;
  endfunction

  // random frames, mostly whole and well-formed
  task automatic run_frames(int n_items);
    int     sent, len, w, h;
    bit     first_fs;
    ibnd_pkg::pixel_t p;
    out_word_t dummy;
    sent = 0;
    dummy = '{pix: '0, fe: 0};
    while (sent < n_items) begin
      w = clamp_side(src_w, ibnd_pkg::MAX_SOURCE_SIDE);
      h = clamp_side(src_h, ibnd_pkg::MAX_SOURCE_SIDE);
      len = w * h;
      if ($urandom_range(9) == 0) len = $urandom_range(len, 1);
      first_fs = ($urandom_range(9) != 0);
      for (int i = 0; i < len && sent < n_items; i++) begin
        case ($urandom_range(9))
          0: p = '0;
          1: p = '1;
          default: p = $urandom;
        endcase
        send_pixel(p, (i == 0) ? first_fs : ($urandom_range(199) == 0), 0, dummy);
        sent++;
      end
    end
  endtask

  // receiver ready, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = 400;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready = 1'b0;
    end else if (idle_mode == 2) out_ch.ready = ($urandom_range(99) >= 77);
    else if (idle_mode == 3) out_ch.ready = ($urandom_range(99) >= 20);
    else out_ch.ready = 1'b1;
  end

  // result checker
  always @(posedge clk) begin : chk
    out_word_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (exp_words.size() == 0) begin
        $error("unexpected output word");
        err_cnt++;
      end else begin
        e = exp_words.pop_front();
        if (out_ch.out_red !== e.pix.red) begin
          $error("out_red exp %0d got %0d", e.pix.red, out_ch.out_red); err_cnt++;
        end
        if (out_ch.out_green !== e.pix.green) begin
          $error("out_green exp %0d got %0d", e.pix.green, out_ch.out_green); err_cnt++;
        end
        if (out_ch.out_blue !== e.pix.blue) begin
          $error("out_blue exp %0d got %0d", e.pix.blue, out_ch.out_blue); err_cnt++;
        end
        if (out_ch.out_alpha !== e.pix.alpha) begin
          $error("out_alpha exp %0d got %0d", e.pix.alpha, out_ch.out_alpha); err_cnt++;
        end
        if (out_ch.frame_end !== e.fe) begin
          $error("frame_end exp %0d got %0d", e.fe, out_ch.frame_end); err_cnt++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > TIMEOUT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // stimulus
  initial begin : stim
    stim_row_t dir_rows[$];
    int        phase_w[10] = '{8, 6, 8, 12, 5, 0, 8191, 3, 16, 7};
    int        phase_h[10] = '{8, 4, 8, 12, 7, 0, 1, 8191, 16, 7};
    int        phase_s[10] = '{4, 3, 8, 3, 2, 0, 2047, 5, 1, 1024};
    int        phase_n[10] = '{120, 100, 100, 150, 100, 40, 150, 100, 260, 100};
    err_cnt = 0; cycle_cnt = 0; idle_mode = 0; hold_req = 0; hold_left = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0; in_ch.frame_start = 1'b0;
    in_ch.in_red = '0; in_ch.in_green = '0; in_ch.in_blue = '0; in_ch.in_alpha = '0;
    out_ch.ready = 1'b1;
    cfg_ch.valid = 1'b0; cfg_ch.index = ibnd_pkg::REG_SOURCE_WIDTH; cfg_ch.data = '0;
    src_w = 256; src_h = 256; out_sz = 32;
    foreach (blk_sum[k, c]) blk_sum[k][c] = '0;
    restart_pos();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: 2x2 box, then clamps and nearest
    dir_rows.insert(dir_rows.size(), cfg_row(ibnd_pkg::REG_SOURCE_WIDTH, 2));
    dir_rows.insert(dir_rows.size(), cfg_row(ibnd_pkg::REG_SOURCE_HEIGHT, 2));
    dir_rows.insert(dir_rows.size(), cfg_row(ibnd_pkg::REG_OUT_SIZE, 1));
    dir_rows.insert(dir_rows.size(), pix_row('1, 1));
    dir_rows.insert(dir_rows.size(), pix_row('1, 0));
    dir_rows.insert(dir_rows.size(), pix_row('1, 0));
    dir_rows.insert(dir_rows.size(), pix_row('1, 0, 1, '1, 1));
    dir_rows.insert(dir_rows.size(), pix_row('0, 1));
    dir_rows.insert(dir_rows.size(), pix_row('0, 0));
    dir_rows.insert(dir_rows.size(), pix_row('0, 0));
    dir_rows.insert(dir_rows.size(), pix_row('0, 0, 1, '0, 1));
    // frame restarted by frame_start after one word
    dir_rows.insert(dir_rows.size(), pix_row(32'h01020304, 1));
    dir_rows.insert(dir_rows.size(), pix_row(32'h0A141E28, 1));
    dir_rows.insert(dir_rows.size(), pix_row(32'h0B151F29, 0));
    dir_rows.insert(dir_rows.size(), pix_row(32'hFF00FF00, 0));
    dir_rows.insert(dir_rows.size(), pix_row(32'h00FF00FF, 0));
    // zero out_size clamps, non-square width switches to nearest
    dir_rows.insert(dir_rows.size(), cfg_row(ibnd_pkg::REG_OUT_SIZE, 0));
    dir_rows.insert(dir_rows.size(), cfg_row(ibnd_pkg::REG_SOURCE_WIDTH, 3));
    dir_rows.insert(dir_rows.size(), pix_row(32'h12345678, 1));
    dir_rows.insert(dir_rows.size(), pix_row(32'h9ABCDEF0, 0));
    dir_rows.insert(dir_rows.size(), pix_row(32'h55AA55AA, 0));
    dir_rows.insert(dir_rows.size(), pix_row(32'hAA55AA55, 0));
    // frame wraps without frame_start
    dir_rows.insert(dir_rows.size(), pix_row(32'hC3C3C3C3, 0));
    dir_rows.insert(dir_rows.size(), pix_row(32'h3C3C3C3C, 0));
    dir_rows.insert(dir_rows.size(), pix_row(32'h11111111, 0));
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) cfg_write(dir_rows[i].idx, dir_rows[i].val);
      else send_pixel(dir_rows[i].pix, dir_rows[i].fs, dir_rows[i].typed, dir_rows[i].ew);
    end

    // random phases over several sizes and idle patterns
    for (int ph = 0; ph < 10; ph++) begin
      cfg_write(ibnd_pkg::REG_SOURCE_WIDTH, phase_w[ph]);
      cfg_write(ibnd_pkg::REG_SOURCE_HEIGHT, phase_h[ph]);
      cfg_write(ibnd_pkg::REG_OUT_SIZE, phase_s[ph]);
      idle_mode = ph % 4;
      if (ph == 8) hold_req = 1;
      run_frames(phase_n[ph]);
    end

    in_ch.valid = 1'b0;
    while (exp_words.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (err_cnt == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
